// ===== hw/rtl/pox_beat_pkg.sv =====
// shared constants, widths and filter helper for the beat estimator
package pox_beat_pkg;

    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 41;

    // input scale, sample / 3.48311 in Q12 after a 16 bit shift
    localparam logic signed [32:0] SCALE_K = 33'sd77067752;

    // band-pass feedback coefficients in Q20, oldest output first
    localparam logic signed [32:0] COEF [4] = '{
        -33'sd180158, 33'sd386573, -33'sd1228734, 33'sd2069683
    };

    localparam logic [9:0]  OXY_MIN     = 10'd500;
    localparam logic [9:0]  OXY_MAX     = 10'd1010;
    localparam logic [10:0] OXY_BASE    = 11'd1100;
    localparam logic [10:0] OXY_TOP     = 11'd1000;
    localparam logic [10:0] OXY_CLAMP   = 11'd999;

    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_MIN_GAP   = 3'd1;
    localparam logic [2:0] CFG_SPM       = 3'd2;
    localparam logic [2:0] CFG_RATE_LOW  = 3'd3;
    localparam logic [2:0] CFG_RATE_HIGH = 3'd4;

    // x[n] - 2 x[n-2] + x[n-4] + rounded feedback, saturated to 32 bits
    function automatic logic signed [31:0] filt_out(
        input logic signed [31:0] x0,
        input logic signed [31:0] x2,
        input logic signed [31:0] x4,
        input logic signed [55:0] fb
    );
        logic signed [55:0] fr;
        logic signed [37:0] sum;
        fr  = (fb + 56'sd524288) >>> 20;
        sum = 38'(x0) + 38'(x4) - (38'(x2) <<< 1) + fr[37:0];
        if (sum > 38'sd2147483647)
            filt_out = 32'sh7fffffff;
        else if (sum < -38'sd2147483648)
            filt_out = 32'sh80000000;
        else
            filt_out = sum[31:0];
    endfunction

endpackage

// ===== hw/rtl/pox_beat_div.sv =====
// shared restoring divider, one quotient bit per cycle
module pox_beat_div
    import pox_beat_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;

    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(DIV_NUM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[DIV_DEN_W])
            begin
                rem_reg <= diff[DIV_DEN_W-1:0];
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DIV_DEN_W-1:0];
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hw/rtl/pulse_oximeter_beat_estimator_unit.sv =====
// Pulse oximeter beat estimator: each accepted item is one red/IR sample pair. Both samples
// are scaled and band-pass filtered with one shared 33x33 multiplier. A sample that gives no
// beat returns an all-zero result once the output register is free. A beat first forms the
// two SpO2 ratio products on the multiplier. It then normalizes them with single-bit shifts
// and runs the shared 48-step divider twice, once for the ratio and once for the heart rate.
// The rings are summed one entry at a time and both averages are taken by reciprocal
// multiplication. A zero denominator product, or a sign mismatch with a nonzero numerator,
// skips the normalization and the ratio divide. The input is not ready while an item is in
// work; a finished result waits in the output register.
module pulse_oximeter_beat_estimator_unit
    import pox_beat_pkg::*;
#(
    parameter int AVG_DEPTH = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [17:0] red_sample,
    input  logic [17:0] ir_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        beat_found,
    output logic [11:0] heart_rate_tenths,
    output logic [9:0]  oxygen_tenths,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int CNT_W = $clog2(AVG_DEPTH + 1);
    localparam int REC_SH = 25;
    // ceil(2^25 / AVG_DEPTH), exact for every ring sum below 2^20
    localparam int REC_MUL = (2**REC_SH + AVG_DEPTH - 1) / AVG_DEPTH;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_FILT    = 11'b00000000010,
        S_CHECK   = 11'b00000000100,
        S_OXMUL   = 11'b00000001000,
        S_NORM    = 11'b00000010000,
        S_OXDIV   = 11'b00000100000,
        S_RATEDIV = 11'b00001000000,
        S_SUM     = 11'b00010000000,
        S_AVGR    = 11'b00100000000,
        S_AVGO    = 11'b01000000000,
        S_DONE    = 11'b10000000000
    } state_t;

    state_t state_reg;

    logic [15:0] thr_reg;
    logic [9:0]  min_gap_reg;
    logic [15:0] spm_reg;
    logic [11:0] rate_low_reg;
    logic [11:0] rate_high_reg;

    logic signed [31:0] ir_x_reg  [5];
    logic signed [31:0] ir_y_reg  [5];
    logic signed [31:0] red_x_reg [5];
    logic signed [31:0] red_y_reg [5];
    logic [17:0] red_in_reg;
    logic [17:0] ir_in_reg;

    logic [15:0] rate_ring_reg [AVG_DEPTH];
    logic [10:0] oxy_ring_reg  [AVG_DEPTH];
    logic [IDX_W-1:0] ring_idx_reg;
    logic [CNT_W-1:0] sum_cnt_reg;
    logic [15:0] gap_reg;

    logic [3:0]          step_reg;
    logic signed [65:0]  prod_reg;
    logic signed [55:0]  acc_reg;
    logic signed [65:0]  num_reg;
    logic [63:0]         un_reg;
    logic [63:0]         ud_reg;
    logic [10:0]         oxy_entry_reg;
    logic [15+CNT_W:0]   rsum_reg;
    logic [10+CNT_W:0]   osum_reg;
    logic                beat_reg;
    logic [11:0]         rate_res_reg;
    logic [9:0]          oxy_res_reg;

    logic                 div_start_reg;
    logic [DIV_NUM_W-1:0] div_num_reg;
    logic [DIV_DEN_W-1:0] div_den_reg;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    logic                out_valid_reg;
    logic                hand_reg;
    logic [11:0]         rate_out_reg;
    logic [9:0]          oxy_out_reg;

    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic [1:0]          cidx;
    logic [65:0]         scaled;
    logic signed [32:0]  thr_neg;
    logic                beat;
    logic [63:0]         num_mag;
    logic [63:0]         den_mag;
    logic [15:0]         ravg;
    logic [10:0]         oavg;
    logic [10:0]         oxy_ent;

    pox_beat_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign cidx = step_reg[1:0] + 2'd2;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_FILT)
        begin
            if (step_reg == 4'd0)
            begin
                mul_a = $signed({15'b0, ir_in_reg});
                mul_b = SCALE_K;
            end
            else if (step_reg == 4'd1)
            begin
                mul_a = $signed({15'b0, red_in_reg});
                mul_b = SCALE_K;
            end
            else if (step_reg < 4'd6)
            begin
                mul_a = COEF[cidx];
                mul_b = 33'(ir_y_reg[cidx]);
            end
            else
            begin
                mul_a = COEF[cidx];
                mul_b = 33'(red_y_reg[cidx]);
            end
        end
        else if (state_reg == S_AVGR)
        begin
            mul_a = 33'(rsum_reg) + 33'(AVG_DEPTH / 2);
            mul_b = 33'(REC_MUL);
        end
        else if (state_reg == S_AVGO)
        begin
            mul_a = 33'(osum_reg) + 33'(AVG_DEPTH / 2);
            mul_b = 33'(REC_MUL);
        end
        else if (step_reg == 4'd0)
        begin
            mul_a = 33'(red_y_reg[4]);
            mul_b = 33'(ir_x_reg[4]);
        end
        else
        begin
            mul_a = 33'(red_x_reg[4]);
            mul_b = 33'(ir_y_reg[4]);
        end
    end

    assign scaled  = prod_reg + 66'sd32768;
    assign thr_neg = -$signed({5'b0, thr_reg, 12'b0});
    assign beat = ($signed({ir_y_reg[4][31], ir_y_reg[4]}) <= thr_neg)
        && (ir_y_reg[2] < ir_y_reg[0]) && (ir_y_reg[2] < ir_y_reg[4])
        && (gap_reg > {6'b0, min_gap_reg});
    assign num_mag = num_reg[65] ? 64'(-num_reg) : num_reg[63:0];
    assign den_mag = prod_reg[65] ? 64'(-prod_reg) : prod_reg[63:0];
    assign ravg    = prod_reg[REC_SH+15:REC_SH];
    assign oavg    = prod_reg[REC_SH+10:REC_SH];
    assign oxy_ent = OXY_BASE - div_quo[10:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= 16'd100;
            min_gap_reg   <= 10'd50;
            spm_reg       <= 16'd6000;
            rate_low_reg  <= 12'd400;
            rate_high_reg <= 12'd1500;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg       <= cfg_data;
                CFG_MIN_GAP:   min_gap_reg   <= cfg_data[9:0];
                CFG_SPM:       spm_reg       <= cfg_data;
                CFG_RATE_LOW:  rate_low_reg  <= cfg_data[11:0];
                CFG_RATE_HIGH: rate_high_reg <= cfg_data[11:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ring_idx_reg  <= '0;
            sum_cnt_reg   <= '0;
            gap_reg       <= '0;
            for (int i = 0; i < 5; i++)
            begin
                ir_x_reg[i]  <= '0;
                ir_y_reg[i]  <= '0;
                red_x_reg[i] <= '0;
                red_y_reg[i] <= '0;
            end
            for (int i = 0; i < AVG_DEPTH; i++)
            begin
                rate_ring_reg[i] <= '0;
                oxy_ring_reg[i]  <= '0;
            end
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        red_in_reg <= red_sample;
                        ir_in_reg  <= ir_sample;
                        for (int i = 0; i < 4; i++)
                        begin
                            ir_x_reg[i]  <= ir_x_reg[i+1];
                            ir_y_reg[i]  <= ir_y_reg[i+1];
                            red_x_reg[i] <= red_x_reg[i+1];
                            red_y_reg[i] <= red_y_reg[i+1];
                        end
                        if (gap_reg != 16'hffff)
                            gap_reg <= gap_reg + 1'b1;
                        step_reg  <= '0;
                        state_reg <= S_FILT;
                    end
                end
                S_FILT:
                begin
                    // product of the previous step is collected here
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'd1)
                        ir_x_reg[4] <= scaled[47:16];
                    else if (step_reg == 4'd2)
                        red_x_reg[4] <= scaled[47:16];
                    else if (step_reg == 4'd3)
                        acc_reg <= prod_reg[55:0];
                    else if (step_reg == 4'd7)
                    begin
                        ir_y_reg[4] <= filt_out(ir_x_reg[0], ir_x_reg[2], ir_x_reg[4], acc_reg);
                        acc_reg     <= prod_reg[55:0];
                    end
                    else if (step_reg == 4'd11)
                    begin
                        red_y_reg[4] <= filt_out(red_x_reg[0], red_x_reg[2], red_x_reg[4],
                                                 acc_reg);
                        state_reg    <= S_CHECK;
                    end
                    else
                        acc_reg <= acc_reg + prod_reg[55:0];
                end
                S_CHECK:
                begin
                    beat_reg <= beat;
                    step_reg <= '0;
                    if (beat)
                        state_reg <= S_OXMUL;
                    else
                    begin
                        rate_res_reg <= '0;
                        oxy_res_reg  <= '0;
                        state_reg    <= S_DONE;
                    end
                end
                S_OXMUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'd1)
                        num_reg <= prod_reg;
                    else if (step_reg == 4'd2)
                    begin
                        un_reg <= num_mag;
                        ud_reg <= den_mag;
                        if (prod_reg == '0)
                        begin
                            oxy_entry_reg <= '0;
                            state_reg     <= S_RATEDIV;
                            div_start_reg <= 1'b1;
                        end
                        else if ((num_reg[65] != prod_reg[65]) && (num_reg != '0))
                        begin
                            oxy_entry_reg <= OXY_CLAMP;
                            state_reg     <= S_RATEDIV;
                            div_start_reg <= 1'b1;
                        end
                        else
                            state_reg <= S_NORM;
                        div_num_reg <= 48'(spm_reg) * 48'd20 + 48'(gap_reg);
                        div_den_reg <= {24'b0, gap_reg, 1'b0};
                    end
                end
                S_NORM:
                begin
                    // one common right shift per cycle until both are below 2^40
                    if ((|un_reg[63:40]) || (|ud_reg[63:40]))
                    begin
                        un_reg <= un_reg >> 1;
                        ud_reg <= ud_reg >> 1;
                    end
                    else if (ud_reg == '0)
                    begin
                        oxy_entry_reg <= '0;
                        state_reg     <= S_RATEDIV;
                        div_start_reg <= 1'b1;
                    end
                    else
                    begin
                        div_num_reg   <= (48'(un_reg) << 8) - (48'(un_reg) << 2)
                                         - (48'(un_reg) << 1) + 48'(ud_reg[40:1]);
                        div_den_reg   <= ud_reg[40:0];
                        div_start_reg <= 1'b1;
                        state_reg     <= S_OXDIV;
                    end
                end
                S_OXDIV:
                begin
                    if (div_done)
                    begin
                        if (div_quo >= 48'(OXY_BASE))
                            oxy_entry_reg <= '0;
                        else if (oxy_ent > OXY_TOP)
                            oxy_entry_reg <= OXY_CLAMP;
                        else
                            oxy_entry_reg <= oxy_ent;
                        div_num_reg   <= 48'(spm_reg) * 48'd20 + 48'(gap_reg);
                        div_den_reg   <= {24'b0, gap_reg, 1'b0};
                        div_start_reg <= 1'b1;
                        state_reg     <= S_RATEDIV;
                    end
                end
                S_RATEDIV:
                begin
                    if (div_done)
                    begin
                        rate_ring_reg[ring_idx_reg] <= (|div_quo[DIV_NUM_W-1:16]) ?
                                                       16'hffff : div_quo[15:0];
                        oxy_ring_reg[ring_idx_reg]  <= oxy_entry_reg;
                        if (ring_idx_reg == IDX_W'(AVG_DEPTH - 1))
                            ring_idx_reg <= '0;
                        else
                            ring_idx_reg <= ring_idx_reg + 1'b1;
                        gap_reg     <= '0;
                        sum_cnt_reg <= '0;
                        rsum_reg    <= '0;
                        osum_reg    <= '0;
                        state_reg   <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    rsum_reg <= rsum_reg + (CNT_W+16)'(rate_ring_reg[sum_cnt_reg[IDX_W-1:0]]);
                    osum_reg <= osum_reg + (CNT_W+11)'(oxy_ring_reg[sum_cnt_reg[IDX_W-1:0]]);
                    sum_cnt_reg <= sum_cnt_reg + 1'b1;
                    if (sum_cnt_reg == CNT_W'(AVG_DEPTH - 1))
                        state_reg <= S_AVGR;
                end
                S_AVGR:
                begin
                    // rate sum times the reciprocal goes into the multiplier here
                    step_reg  <= '0;
                    state_reg <= S_AVGO;
                end
                S_AVGO:
                begin
                    // rate average lands first, the SpO2 average in the cycle after it
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'd0)
                    begin
                        if (ravg < 16'(rate_low_reg) || ravg > 16'(rate_high_reg))
                            rate_res_reg <= '0;
                        else
                            rate_res_reg <= ravg[11:0];
                    end
                    else
                    begin
                        if (oavg < 11'(OXY_MIN) || oavg > 11'(OXY_MAX))
                            oxy_res_reg <= '0;
                        else
                            oxy_res_reg <= oavg[9:0];
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        hand_reg      <= beat_reg;
                        rate_out_reg  <= rate_res_reg;
                        oxy_out_reg   <= oxy_res_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign beat_found        = hand_reg;
    assign heart_rate_tenths = rate_out_reg;
    assign oxygen_tenths     = oxy_out_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready while an item is in work");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_OXDIV || state_reg == S_RATEDIV))
        else $error("divider finished outside a divide step");

    a_no_beat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !beat_found |-> heart_rate_tenths == '0 && oxygen_tenths == '0)
        else $error("nonzero result without a beat");

    a_ring_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring_idx_reg <= IDX_W'(AVG_DEPTH - 1))
        else $error("ring index out of range");

endmodule

// ===== bench/pulse_oximeter_beat_estimator_unit_test.sv =====
// testbench for the pulse oximeter beat estimator with its own filter and beat predictor
module pulse_oximeter_beat_estimator_unit_test;
    import pox_beat_pkg::*;

    localparam int RING_DEPTH = 5;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic [17:0] red;
        logic [17:0] ir;
    } sample_pair_t;

    typedef struct {
        logic        hand;
        logic [11:0] rate;
        logic [9:0]  oxy;
    } beat_report_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [17:0] red_sample;
    logic [17:0] ir_sample;
    logic        out_valid;
    logic        out_ready;
    logic        beat_found;
    logic [11:0] heart_rate_tenths;
    logic [9:0]  oxygen_tenths;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    pulse_oximeter_beat_estimator_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .red_sample(red_sample), .ir_sample(ir_sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .beat_found(beat_found), .heart_rate_tenths(heart_rate_tenths),
        .oxygen_tenths(oxygen_tenths),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    sample_pair_t pending_pairs[$];
    beat_report_t expected_reports[$];
    int  error_count;

    // predictor state, channel 0 is ir and channel 1 is red
    longint filt_x[2][5];
    longint filt_y[2][5];
    int unsigned rate_ring[RING_DEPTH];
    int unsigned oxy_ring[RING_DEPTH];
    int unsigned ring_pos;
    int unsigned beat_gap;
    int unsigned threshold_reg, min_gap_reg, spm_reg, rate_low_reg, rate_high_reg;

    logic in_took, out_took;
    int   send_wait, stall_left;
    bit   send_idling, recv_idling;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("tb: failure");
        $finish;
    end

    function automatic void filter_step(int ch, logic [17:0] sample);
        longint fb;
        longint y;
        for (int i = 0; i < 4; i++)
        begin
            filt_x[ch][i] = filt_x[ch][i + 1];
            filt_y[ch][i] = filt_y[ch][i + 1];
        end
        filt_x[ch][4] = (longint'(sample) * 64'd77067752 + 64'd32768) >>> 16;
        fb = -64'sd180158 * filt_y[ch][0] + 64'sd386573 * filt_y[ch][1]
             - 64'sd1228734 * filt_y[ch][2] + 64'sd2069683 * filt_y[ch][3];
        y = filt_x[ch][0] + filt_x[ch][4] - 2 * filt_x[ch][2] + ((fb + 64'sd524288) >>> 20);
        if (y > 64'sd2147483647)
            y = 64'sd2147483647;
        else if (y < -64'sd2147483648)
            y = -64'sd2147483648;
        filt_y[ch][4] = y;
    endfunction

    function automatic int unsigned spo2_entry();
        longint num, den, un, ud, q;
        num = filt_y[1][4] * filt_x[0][4];
        den = filt_x[1][4] * filt_y[0][4];
        if (den == 0)
            return 0;
        if (((num < 0) != (den < 0)) && num != 0)
            return 999;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        while (un >= (64'sd1 << 40) || ud >= (64'sd1 << 40))
        begin
            un = un >>> 1;
            ud = ud >>> 1;
        end
        if (ud == 0)
            return 0;
        q = (250 * un + ud / 2) / ud;
        if (q >= 1100)
            return 0;
        if (1100 - q > 1000)
            return 999;
        return int'(1100 - q);
    endfunction

    function automatic beat_report_t predict_beat(sample_pair_t p);
        beat_report_t r;
        bit beat;
        int unsigned rate, rsum, osum, ravg, oavg;
        filter_step(0, p.ir);
        filter_step(1, p.red);
        if (beat_gap < 65535)
            beat_gap++;
        beat = filt_y[0][4] <= -(longint'(threshold_reg) * 4096)
            && filt_y[0][2] < filt_y[0][0] && filt_y[0][2] < filt_y[0][4]
            && beat_gap > min_gap_reg;
        r.hand = 1'b0;
        r.rate = '0;
        r.oxy  = '0;
        if (!beat)
            return r;
        rate = (20 * spm_reg + beat_gap) / (2 * beat_gap);
        rate_ring[ring_pos] = (rate > 65535) ? 65535 : rate;
        oxy_ring[ring_pos] = spo2_entry();
        ring_pos = (ring_pos + 1) % RING_DEPTH;
        beat_gap = 0;
        rsum = 0;
        osum = 0;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            rsum += rate_ring[i];
            osum += oxy_ring[i];
        end
        ravg = (rsum + RING_DEPTH / 2) / RING_DEPTH;
        oavg = (osum + RING_DEPTH / 2) / RING_DEPTH;
        if (ravg < rate_low_reg || ravg > rate_high_reg)
            ravg = 0;
        if (oavg < OXY_MIN || oavg > OXY_MAX)
            oavg = 0;
        r.hand = 1'b1;
        r.rate = ravg[11:0];
        r.oxy  = oavg[9:0];
        return r;
    endfunction

    // input driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            red_sample <= '0;
            ir_sample  <= '0;
            send_wait  <= 0;
        end
        else if (!in_valid || in_took)
        begin
            if (send_wait > 0)
            begin
                in_valid  <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (pending_pairs.size() > 0)
            begin
                red_sample <= pending_pairs[0].red;
                ir_sample  <= pending_pairs[0].ir;
                void'(pending_pairs.pop_front());
                in_valid   <= 1'b1;
                if ($urandom_range(0, 99) < 3)
                    send_idling = ~send_idling;
                send_wait  <= send_idling ? $urandom_range(0, 19) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side stalls
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_took)
        begin
            if ($urandom_range(0, 99) < 3)
                recv_idling = ~recv_idling;
            stall_left <= recv_idling ? $urandom_range(0, 19) : 0;
            out_ready  <= !recv_idling;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // monitor: predict on input items, check result items
    always @(posedge clk or negedge rst_n)
    begin
        beat_report_t want;
        sample_pair_t got_in;
        if (!rst_n)
        begin
            in_took  <= 1'b0;
            out_took <= 1'b0;
        end
        else
        begin
            in_took  <= in_valid && in_ready;
            out_took <= out_valid && out_ready;
            if (in_valid && in_ready)
            begin
                got_in.red = red_sample;
                got_in.ir  = ir_sample;
                expected_reports.push_back(predict_beat(got_in));
            end
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t unexpected item: beat %0d rate %0d oxy %0d", $time,
                             beat_found, heart_rate_tenths, oxygen_tenths);
                    error_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (beat_found !== want.hand)
                    begin
                        $display("%0t beat_found expected %0d actual %0d", $time,
                                 want.hand, beat_found);
                        error_count++;
                    end
                    if (heart_rate_tenths !== want.rate)
                    begin
                        $display("%0t heart_rate_tenths expected %0d actual %0d", $time,
                                 want.rate, heart_rate_tenths);
                        error_count++;
                    end
                    if (oxygen_tenths !== want.oxy)
                    begin
                        $display("%0t oxygen_tenths expected %0d actual %0d", $time,
                                 want.oxy, oxygen_tenths);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_pairs.size() > 0 || in_valid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_THRESHOLD: threshold_reg = value;
            CFG_MIN_GAP:   min_gap_reg   = value & 16'h3ff;
            CFG_SPM:       spm_reg       = value;
            CFG_RATE_LOW:  rate_low_reg  = value & 16'hfff;
            CFG_RATE_HIGH: rate_high_reg = value & 16'hfff;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int t, int g, int s, int lo, int hi);
        write_reg(CFG_THRESHOLD, 16'(t));
        write_reg(CFG_MIN_GAP, 16'(g));
        write_reg(CFG_SPM, 16'(s));
        write_reg(CFG_RATE_LOW, 16'(lo));
        write_reg(CFG_RATE_HIGH, 16'(hi));
    endtask

    function automatic void push_pair(int red, int ir);
        sample_pair_t p;
        p.red = 18'(red);
        p.ir  = 18'(ir);
        pending_pairs.push_back(p);
    endfunction

    // sawtooth pulses: slow rise then a sharp drop, which the band-pass turns into deep valleys
    task automatic add_pulses(int count, int noise_pct);
        int period, base, amp, red_base, red_amp, ph, ir_v, red_v;
        bit red_off;
        period   = $urandom_range(30, 140);
        base     = $urandom_range(20000, 150000);
        amp      = $urandom_range(2000, 100000);
        red_base = $urandom_range(0, 150000);
        red_amp  = $urandom_range(0, 100000);
        red_off  = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                push_pair($urandom_range(0, 262143), $urandom_range(0, 262143));
            else
            begin
                ph    = k % period;
                ir_v  = base + amp * ph / period + $urandom_range(0, 300);
                red_v = red_off ? 0 : red_base + red_amp * ph / period + $urandom_range(0, 300);
                push_pair(red_v > 262143 ? 262143 : red_v, ir_v > 262143 ? 262143 : ir_v);
            end
            if ($urandom_range(0, 399) == 0)
                period = $urandom_range(30, 140);
        end
    endtask

    initial
    begin
        error_count = 0;
        send_idling = 1'b0;
        recv_idling = 1'b0;
        for (int c = 0; c < 2; c++)
            for (int i = 0; i < 5; i++)
            begin
                filt_x[c][i] = 0;
                filt_y[c][i] = 0;
            end
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            rate_ring[i] = 0;
            oxy_ring[i]  = 0;
        end
        ring_pos      = 0;
        beat_gap      = 0;
        threshold_reg = 100;
        min_gap_reg   = 50;
        spm_reg       = 6000;
        rate_low_reg  = 400;
        rate_high_reg = 1500;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // field extremes and a hard step that drives the filter to saturation
        push_pair(0, 0);
        push_pair(262143, 262143);
        push_pair(0, 262143);
        push_pair(262143, 0);
        for (int k = 0; k < 8; k++)
            push_pair(262143, 262143);
        for (int k = 0; k < 8; k++)
            push_pair(0, 0);
        push_pair(131072, 131071);
        push_pair(87381, 174762);

        // lowest threshold, a gap of 1 and a wide 0 to 4000 rate window: many beats
        set_regs(0, 1, 65535, 0, 4000);
        write_reg(CFG_UNUSED, 16'hffff);
        add_pulses(150, 5);
        add_pulses(150, 0);

        set_regs(100, 50, 6000, 400, 1500);
        for (int n = 0; n < 4; n++)
            add_pulses(100, 3);

        // extreme high settings, beats cannot pass the gap
        set_regs(65535, 1023, 60, 4000, 0);
        add_pulses(100, 50);

        set_regs(16'hffff, 16'hffff, 60, 16'hffff, 16'hffff);
        add_pulses(50, 0);

        for (int n = 0; n < 4; n++)
        begin
            set_regs($urandom_range(0, 300), $urandom_range(1, 40), $urandom_range(60, 65535),
                     $urandom_range(0, 800), $urandom_range(800, 4000));
            add_pulses(100, 10);
            add_pulses(50, 0);
        end
        for (int k = 0; k < 50; k++)
            push_pair($urandom_range(0, 262143), $urandom_range(0, 262143));

        wait_idle();
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pox_beat_pkg.sv
hw/rtl/pox_beat_div.sv
hw/rtl/pulse_oximeter_beat_estimator_unit.sv
bench/pulse_oximeter_beat_estimator_unit_test.sv
